>>> rtl/tpam_pkg.sv
// Shared types, widths and constants for the three-point affine map.
// Used by tpam_front, tpam_div and three_point_affine_map; no dependencies.
package tpam_pkg;

    // Saturation range of the results (signed COORD_BITS).
    localparam int COORD_BITS = 16;

    // Fixed field widths of the ports.
    localparam int CW      = 16;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 2;
    localparam int STAT_W  = 2;

    // Internal widths.
    localparam int EW  = CW + 1;        // edge vectors, point offsets
    localparam int PW  = 2 * EW;        // edge products
    localparam int DW  = PW + 1;        // det, k1n, k2n
    localparam int DDW = DW + 1;        // |2*det|
    localparam int MW  = DW + EW;       // k*edge products
    localparam int BW  = CW + DW;       // base*det products
    localparam int SW  = MW + 2;        // sum of three products
    localparam int NW  = SW + 2;        // 2*sum + det
    localparam int QW  = COORD_BITS + 1;// quotient bits kept by the divider
    localparam int LW  = NW + QW;       // divider compare width

    localparam int FRONT_LAT = 7;
    localparam int DIV_LAT   = QW + 2;

    localparam logic [QW-1:0] HI_Q  = QW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_Q = QW'(64'd1 << (COORD_BITS - 1));

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;

    // Packed as in the register: dy 63:48, dx 47:32, sy 31:16, sx 15:0.
    typedef struct packed {
        coord_t dy;
        coord_t dx;
        coord_t sy;
        coord_t sx;
    } pair_t;

    typedef struct packed {
        logic valid;
        logic degen;
    } tag_t;

    typedef struct packed {
        logic          neg;
        logic [NW-1:0] mag;
    } num_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PAIR0 = 2'd0,
        REG_PAIR1 = 2'd1,
        REG_PAIR2 = 2'd2
    } reg_idx_t;

    function automatic edge_t ext(input coord_t a);
        ext = {a[CW-1], a};
    endfunction

endpackage

>>> rtl/tpam_front.sv
// Front pipeline: offsets, det, k1n/k2n, numerators, sign and magnitude.
// Depends on tpam_pkg. Seven stages; config-derived terms are held in
// registers refreshed every cycle.
module tpam_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  tpam_pkg::coord_t         x_in,
    input  tpam_pkg::coord_t         y_in,
    input  tpam_pkg::pair_t          pair0,
    input  tpam_pkg::pair_t          pair1,
    input  tpam_pkg::pair_t          pair2,
    output tpam_pkg::tag_t           tag,
    output tpam_pkg::num_t           num_x,
    output tpam_pkg::num_t           num_y,
    output logic [tpam_pkg::DDW-1:0] dabs
);
    import tpam_pkg::*;

    // config-derived terms
    edge_t ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    edge_t fx1_reg, fy1_reg, fx2_reg, fy2_reg;
    edge_t ex1_next, ey1_next, ex2_next, ey2_next;
    edge_t fx1_next, fy1_next, fx2_next, fy2_next;
    logic signed [PW-1:0] detp1_reg, detp2_reg, detp1_next, detp2_next;
    logic signed [DW-1:0] det_reg, det_next;
    logic [DW-1:0]        abs_det;
    logic [DDW-1:0]       dabs_reg, dabs_next;

    // item stages
    logic [FRONT_LAT-1:0] v_reg, v_next;
    edge_t px_reg, py_reg, px_next, py_next;
    logic signed [PW-1:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic signed [PW-1:0] ma_next, mb_next, mc_next, md_next;
    logic signed [DW-1:0] k1_reg, k2_reg, k1_next, k2_next;
    logic signed [MW-1:0] mx1_reg, mx2_reg, my1_reg, my2_reg;
    logic signed [MW-1:0] mx1_next, mx2_next, my1_next, my2_next;
    logic signed [BW-1:0] bx_reg, by_reg, bx_next, by_next;
    logic signed [SW-1:0] sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic signed [NW-1:0] n_x_reg, n_y_reg, n_x_next, n_y_next;
    num_t                 num_x_reg, num_y_reg, num_x_next, num_y_next;

    always_comb
    begin
        ex1_next = ext(pair1.sx) - ext(pair0.sx);
        ey1_next = ext(pair1.sy) - ext(pair0.sy);
        ex2_next = ext(pair2.sx) - ext(pair0.sx);
        ey2_next = ext(pair2.sy) - ext(pair0.sy);
        fx1_next = ext(pair1.dx) - ext(pair0.dx);
        fy1_next = ext(pair1.dy) - ext(pair0.dy);
        fx2_next = ext(pair2.dx) - ext(pair0.dx);
        fy2_next = ext(pair2.dy) - ext(pair0.dy);
        detp1_next = ex1_reg * ey2_reg;
        detp2_next = ey1_reg * ex2_reg;
        det_next   = DW'(detp1_reg) - DW'(detp2_reg);
        abs_det    = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        dabs_next  = {abs_det, 1'b0};

        v_next  = {v_reg[FRONT_LAT-2:0], in_valid};
        px_next = ext(x_in) - ext(pair0.sx);
        py_next = ext(y_in) - ext(pair0.sy);
        ma_next = px_reg * ey2_reg;
        mb_next = ex2_reg * py_reg;
        mc_next = ex1_reg * py_reg;
        md_next = ey1_reg * px_reg;
        k1_next = DW'(ma_reg) - DW'(mb_reg);
        k2_next = DW'(mc_reg) - DW'(md_reg);
        mx1_next = k1_reg * fx1_reg;
        mx2_next = k2_reg * fx2_reg;
        my1_next = k1_reg * fy1_reg;
        my2_next = k2_reg * fy2_reg;
        bx_next  = $signed(pair0.dx) * det_reg;
        by_next  = $signed(pair0.dy) * det_reg;
        sum_x_next = SW'(bx_reg) + SW'(mx1_reg) + SW'(mx2_reg);
        sum_y_next = SW'(by_reg) + SW'(my1_reg) + SW'(my2_reg);
        n_x_next = (NW'(sum_x_reg) <<< 1) + NW'(det_reg);
        n_y_next = (NW'(sum_y_reg) <<< 1) + NW'(det_reg);
        num_x_next.neg = n_x_reg[NW-1] ^ det_reg[DW-1];
        num_x_next.mag = n_x_reg[NW-1] ? NW'(-n_x_reg) : NW'(n_x_reg);
        num_y_next.neg = n_y_reg[NW-1] ^ det_reg[DW-1];
        num_y_next.mag = n_y_reg[NW-1] ? NW'(-n_y_reg) : NW'(n_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex1_reg   <= ex1_next;
        ey1_reg   <= ey1_next;
        ex2_reg   <= ex2_next;
        ey2_reg   <= ey2_next;
        fx1_reg   <= fx1_next;
        fy1_reg   <= fy1_next;
        fx2_reg   <= fx2_next;
        fy2_reg   <= fy2_next;
        detp1_reg <= detp1_next;
        detp2_reg <= detp2_next;
        det_reg   <= det_next;
        dabs_reg  <= dabs_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        mc_reg    <= mc_next;
        md_reg    <= md_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        mx1_reg   <= mx1_next;
        mx2_reg   <= mx2_next;
        my1_reg   <= my1_next;
        my2_reg   <= my2_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        sum_x_reg <= sum_x_next;
        sum_y_reg <= sum_y_next;
        n_x_reg   <= n_x_next;
        n_y_reg   <= n_y_next;
        num_x_reg <= num_x_next;
        num_y_reg <= num_y_next;
    end

    assign tag.valid = v_reg[FRONT_LAT-1];
    assign tag.degen = (det_reg == '0);
    assign num_x     = num_x_reg;
    assign num_y     = num_y_reg;
    assign dabs      = dabs_reg;

endmodule

>>> rtl/tpam_div.sv
// Pipelined restoring divider with saturation, one quotient bit per stage.
// Depends on tpam_pkg.
module tpam_div
(
    input  logic                     clk,
    input  tpam_pkg::num_t           num,
    input  logic [tpam_pkg::DDW-1:0] dabs,
    output tpam_pkg::coord_t         q,
    output logic                     sat
);
    import tpam_pkg::*;

    logic [NW-1:0] rem_reg [0:QW];
    logic [NW-1:0] rem_next [0:QW];
    logic [QW-1:0] q_reg [0:QW];
    logic [QW-1:0] q_next [0:QW];
    logic          neg_reg [0:QW];
    logic          neg_next [0:QW];
    logic          ovf_reg [0:QW];
    logic          ovf_next [0:QW];
    logic [LW-1:0] trial;
    logic [QW-1:0] uq;
    logic [QW-1:0] val;
    logic          sat_c;
    coord_t        q_out_reg, q_out_next;
    logic          sat_reg, sat_next;

    always_comb
    begin
        // overflow check: quotient would not fit QW bits
        rem_next[0] = num.mag;
        q_next[0]   = '0;
        neg_next[0] = num.neg;
        ovf_next[0] = (LW'(num.mag) >= (LW'(dabs) << QW));
        trial       = '0;
        for (int s = 0; s < QW; s++)
        begin
            trial         = LW'(dabs) << (QW - 1 - s);
            neg_next[s+1] = neg_reg[s];
            ovf_next[s+1] = ovf_reg[s];
            if (LW'(rem_reg[s]) >= trial)
            begin
                rem_next[s+1] = rem_reg[s] - NW'(trial);
                q_next[s+1]   = {q_reg[s][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[s+1] = rem_reg[s];
                q_next[s+1]   = {q_reg[s][QW-2:0], 1'b0};
            end
        end

        // clamp to the signed COORD_BITS range
        uq = q_reg[QW];
        if (neg_reg[QW])
        begin
            sat_c = ovf_reg[QW] || (uq > NEG_Q);
            val   = QW'(0) - (sat_c ? NEG_Q : uq);
        end
        else
        begin
            sat_c = ovf_reg[QW] || (uq > HI_Q);
            val   = sat_c ? HI_Q : uq;
        end
        q_out_next = val[CW-1:0];
        sat_next   = sat_c;
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= QW; s++)
        begin
            rem_reg[s] <= rem_next[s];
            q_reg[s]   <= q_next[s];
            neg_reg[s] <= neg_next[s];
            ovf_reg[s] <= ovf_next[s];
        end
        q_out_reg <= q_out_next;
        sat_reg   <= sat_next;
    end

    assign q   = q_out_reg;
    assign sat = sat_reg;

endmodule

>>> rtl/three_point_affine_map.sv
// Top level of the three-point affine map; uses tpam_pkg, tpam_front, tpam_div.
// Throughput: one word per cycle, busy is always low.
// Pipeline: 7 front stages plus QW+2 divider stages (bit-per-stage divider); the
// result strobe rises together with its word at the end of the last divider stage.
// Reset: asynchronous, active low; clears the point pairs and all valid bits.
// Results are shown for one cycle on done; the receiver cannot stall.
module three_point_affine_map
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tpam_pkg::coord_t           x_in,
    input  tpam_pkg::coord_t           y_in,
    input  logic                       wr_en,
    input  logic [tpam_pkg::IDX_W-1:0] wr_index,
    input  logic [tpam_pkg::CFG_W-1:0] wr_data,
    output logic                       done,
    output tpam_pkg::coord_t           x_out,
    output tpam_pkg::coord_t           y_out,
    output logic [tpam_pkg::STAT_W-1:0] status
);
    import tpam_pkg::*;

    // point pair registers
    pair_t pair0_reg, pair1_reg, pair2_reg;
    pair_t pair0_next, pair1_next, pair2_next;

    tag_t                 front_tag;
    num_t                 num_x, num_y;
    logic [DDW-1:0]       dabs;
    coord_t               qx, qy;
    logic                 sat_x, sat_y;

    // tag chain alongside the dividers
    tag_t tag_reg [0:DIV_LAT-1];
    tag_t tag_next [0:DIV_LAT-1];
    tag_t tag_out;
    status_t stat_c;

    // nothing ever holds the input side
    assign busy = 1'b0;

    // config writes; an index past the list is dropped
    always_comb
    begin
        pair0_next = pair0_reg;
        pair1_next = pair1_reg;
        pair2_next = pair2_reg;
        if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_PAIR0: pair0_next = pair_t'(wr_data);
                REG_PAIR1: pair1_next = pair_t'(wr_data);
                REG_PAIR2: pair2_next = pair_t'(wr_data);
                default:   ;
            endcase
        end
    end

    // advance the tag with the divider stages
    always_comb
    begin
        tag_next[0] = front_tag;
        for (int s = 1; s < DIV_LAT; s++)
        begin
            tag_next[s] = tag_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair0_reg <= '0;
            pair1_reg <= '0;
            pair2_reg <= '0;
            for (int s = 0; s < DIV_LAT; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            pair0_reg <= pair0_next;
            pair1_reg <= pair1_next;
            pair2_reg <= pair2_next;
            for (int s = 0; s < DIV_LAT; s++)
            begin
                tag_reg[s] <= tag_next[s];
            end
        end
    end

    // offsets, det, numerators, sign/magnitude split
    tpam_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .x_in     (x_in),
        .y_in     (y_in),
        .pair0    (pair0_reg),
        .pair1    (pair1_reg),
        .pair2    (pair2_reg),
        .tag      (front_tag),
        .num_x    (num_x),
        .num_y    (num_y),
        .dabs     (dabs)
    );

    // one divider per coordinate, sharing |2*det|
    tpam_div u_div_x
    (
        .clk  (clk),
        .num  (num_x),
        .dabs (dabs),
        .q    (qx),
        .sat  (sat_x)
    );

    tpam_div u_div_y
    (
        .clk  (clk),
        .num  (num_y),
        .dabs (dabs),
        .q    (qy),
        .sat  (sat_y)
    );

    // degenerate triangle forces zero outputs and ST_DEGEN; else saturation of either coordinate flags ST_SAT
    assign tag_out = tag_reg[DIV_LAT-1];

    always_comb
    begin
        if (tag_out.degen)
        begin
            stat_c = ST_DEGEN;
        end
        else if (sat_x || sat_y)
        begin
            stat_c = ST_SAT;
        end
        else
        begin
            stat_c = ST_OK;
        end
    end

    assign done   = tag_out.valid;
    assign x_out  = tag_out.degen ? coord_t'(0) : qx;
    assign y_out  = tag_out.degen ? coord_t'(0) : qy;
    assign status = stat_c;

endmodule
